>>> rtl/rlsc_pkg.sv
package rlsc_pkg;

	localparam int SLOTS_DEFAULT = 16;
	localparam int KEY_W = 64;
	localparam int COUNT_W = 16;
	localparam int SLOT_W = 4;
	localparam int STATUS_W = 2;

	localparam logic KIND_ACQUIRE = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_RELEASE = 2'd2;

	localparam logic [1:0] RD_NONE = 2'd0;
	localparam logic [1:0] RD_HEAD = 2'd1;
	localparam logic [1:0] RD_LINK = 2'd2;
	localparam logic [1:0] RD_SLOT = 2'd3;

	localparam logic [1:0] RES_FILL = 2'd0;
	localparam logic [1:0] RES_MOVED = 2'd1;
	localparam logic [1:0] RES_FULL = 2'd2;
	localparam logic [1:0] RES_REL = 2'd3;

	typedef struct packed {
		logic kind;
		logic [KEY_W-1:0] key;
		logic [SLOT_W-1:0] slot_in;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot_out;
		logic hit;
		logic evicted;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic [1:0] rd_src;
		logic walk_init;
		logic walk_step;
		logic fill;
		logic claim;
		logic unlink;
		logic relink;
		logic rel_dec;
		logic emit;
		logic [1:0] res;
	} dp_cmd_t;

	typedef struct packed {
		logic kind_rel;
		logic head_none;
		logic key_match;
		logic link_none;
		logic free_avail;
		logic tgt_valid;
		logic tprev_none;
		logic rel_ok;
	} dp_stat_t;

endpackage

>>> rtl/rlsc_ctrl.sv
module rlsc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	output logic done,
	input rlsc_pkg::dp_stat_t stat,
	output rlsc_pkg::dp_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DISPATCH = 3'd1;
	localparam logic [2:0] S_WALK = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_MOVE = 3'd4;
	localparam logic [2:0] S_RELINK = 3'd5;
	localparam logic [2:0] S_RELEASE = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic done_q;

	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_nxt = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.kind_rel) begin
					cmd.rd_src = rlsc_pkg::RD_SLOT;
					state_nxt = S_RELEASE;
				end else begin
					cmd.walk_init = 1'b1;
					if (stat.head_none) begin
						state_nxt = S_DECIDE;
					end else begin
						cmd.rd_src = rlsc_pkg::RD_HEAD;
						state_nxt = S_WALK;
					end
				end
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				if (stat.key_match) begin
					state_nxt = S_MOVE;
				end else if (stat.link_none) begin
					state_nxt = S_DECIDE;
				end else begin
					cmd.rd_src = rlsc_pkg::RD_LINK;
				end
			end
			S_DECIDE: begin
				if (stat.free_avail) begin
					cmd.fill = 1'b1;
					cmd.emit = 1'b1;
					cmd.res = rlsc_pkg::RES_FILL;
					state_nxt = S_IDLE;
				end else if (stat.tgt_valid) begin
					cmd.claim = 1'b1;
					state_nxt = S_MOVE;
				end else begin
					cmd.emit = 1'b1;
					cmd.res = rlsc_pkg::RES_FULL;
					state_nxt = S_IDLE;
				end
			end
			S_MOVE: begin
				if (stat.tprev_none) begin
					cmd.emit = 1'b1;
					cmd.res = rlsc_pkg::RES_MOVED;
					state_nxt = S_IDLE;
				end else begin
					cmd.unlink = 1'b1;
					state_nxt = S_RELINK;
				end
			end
			S_RELINK: begin
				cmd.relink = 1'b1;
				cmd.emit = 1'b1;
				cmd.res = rlsc_pkg::RES_MOVED;
				state_nxt = S_IDLE;
			end
			S_RELEASE: begin
				cmd.rel_dec = stat.rel_ok;
				cmd.emit = 1'b1;
				cmd.res = rlsc_pkg::RES_REL;
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q <= cmd.emit;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

`ifndef NO_ASSERTIONS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("Result strobe lasted more than one cycle.");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("Result strobe while the controller is busy.");
`endif

endmodule

>>> rtl/rlsc_datapath.sv
module rlsc_datapath #(
	parameter int SLOTS = rlsc_pkg::SLOTS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input rlsc_pkg::req_t request,
	input rlsc_pkg::dp_cmd_t cmd,
	output rlsc_pkg::dp_stat_t stat,
	output rlsc_pkg::rsp_t result
);

	localparam int IW = $clog2(SLOTS);
	localparam int LW = $clog2(SLOTS + 1);
	localparam int SW = rlsc_pkg::SLOT_W;
	localparam int CW = rlsc_pkg::COUNT_W;
	localparam logic [LW-1:0] NONE = LW'(SLOTS);

	logic [rlsc_pkg::KEY_W-1:0] key_mem [SLOTS];
	logic [CW-1:0] cnt_mem [SLOTS];
	logic [LW-1:0] link_mem [SLOTS];

	rlsc_pkg::req_t req_q;
	rlsc_pkg::rsp_t rsp_q;
	logic [LW-1:0] free_head_q;
	logic [LW-1:0] recent_head_q;
	logic [LW-1:0] cur_q;
	logic [LW-1:0] prev_q;
	logic [LW-1:0] tgt_q;
	logic [LW-1:0] tprev_q;
	logic [LW-1:0] tnext_q;
	logic hit_q;
	logic [rlsc_pkg::KEY_W-1:0] key_rd_q;
	logic [CW-1:0] cnt_rd_q;
	logic [LW-1:0] link_rd_q;

	logic rd_en;
	logic [IW-1:0] rd_addr;
	logic [IW+SW-1:0] sin_ext;
	logic [IW-1:0] sin_idx;
	logic [IW-1:0] free_idx;
	logic [IW-1:0] tgt_idx;
	logic [IW+SW-1:0] free_out_ext;
	logic [IW+SW-1:0] tgt_out_ext;
	logic [LW+SW-1:0] sin_cmp;
	logic [LW+SW-1:0] free_cmp;
	logic key_match;
	logic rel_ok;
	logic [CW-1:0] cnt_inc;

	logic key_we;
	logic [IW-1:0] key_wa;
	logic cnt_we;
	logic [IW-1:0] cnt_wa;
	logic [CW-1:0] cnt_wd;
	logic link_we;
	logic [IW-1:0] link_wa;
	logic [LW-1:0] link_wd;

	assign sin_ext = {{IW{1'b0}}, req_q.slot_in};
	assign sin_idx = sin_ext[IW-1:0];
	assign free_idx = free_head_q[IW-1:0];
	assign tgt_idx = tgt_q[IW-1:0];
	assign free_out_ext = {{SW{1'b0}}, free_idx};
	assign tgt_out_ext = {{SW{1'b0}}, tgt_idx};
	assign sin_cmp = {{LW{1'b0}}, req_q.slot_in};
	assign free_cmp = {{SW{1'b0}}, free_head_q};

	assign key_match = (key_rd_q == req_q.key);
	assign rel_ok = (sin_cmp < free_cmp) && (cnt_rd_q != '0);
	assign cnt_inc = (cnt_rd_q == {CW{1'b1}}) ? cnt_rd_q : cnt_rd_q + 1'b1;

	assign rd_en = (cmd.rd_src != rlsc_pkg::RD_NONE);

	always_comb begin
		case (cmd.rd_src)
			rlsc_pkg::RD_HEAD: rd_addr = recent_head_q[IW-1:0];
			rlsc_pkg::RD_LINK: rd_addr = link_rd_q[IW-1:0];
			rlsc_pkg::RD_SLOT: rd_addr = sin_idx;
			default: rd_addr = '0;
		endcase
	end

	always_comb begin
		key_we = cmd.fill || cmd.claim;
		key_wa = cmd.fill ? free_idx : tgt_idx;

		cnt_we = 1'b0;
		cnt_wa = tgt_idx;
		cnt_wd = CW'(1);
		if (cmd.fill) begin
			cnt_we = 1'b1;
			cnt_wa = free_idx;
		end else if (cmd.claim) begin
			cnt_we = 1'b1;
		end else if (cmd.walk_step && key_match) begin
			cnt_we = 1'b1;
			cnt_wa = cur_q[IW-1:0];
			cnt_wd = cnt_inc;
		end else if (cmd.rel_dec) begin
			cnt_we = 1'b1;
			cnt_wa = sin_idx;
			cnt_wd = cnt_rd_q - 1'b1;
		end

		link_we = cmd.fill || cmd.unlink || cmd.relink;
		link_wa = tgt_idx;
		link_wd = recent_head_q;
		if (cmd.fill) begin
			link_wa = free_idx;
		end else if (cmd.unlink) begin
			link_wa = tprev_q[IW-1:0];
			link_wd = tnext_q;
		end
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_wa] <= req_q.key;
		end
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (rd_en) begin
			key_rd_q <= key_mem[rd_addr];
			cnt_rd_q <= cnt_mem[rd_addr];
			link_rd_q <= link_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= request;
		end
		if (cmd.walk_init) begin
			cur_q <= recent_head_q;
			prev_q <= NONE;
			tgt_q <= NONE;
			tprev_q <= NONE;
			hit_q <= 1'b0;
		end else if (cmd.walk_step) begin
			cur_q <= link_rd_q;
			prev_q <= cur_q;
			if (key_match || (cnt_rd_q == '0)) begin
				tgt_q <= cur_q;
				tprev_q <= prev_q;
				tnext_q <= link_rd_q;
			end
			if (key_match) begin
				hit_q <= 1'b1;
			end
		end
		if (cmd.emit) begin
			case (cmd.res)
				rlsc_pkg::RES_FILL: begin
					rsp_q.slot_out <= free_out_ext[SW-1:0];
					rsp_q.hit <= 1'b0;
					rsp_q.evicted <= 1'b0;
					rsp_q.status <= rlsc_pkg::ST_OK;
				end
				rlsc_pkg::RES_MOVED: begin
					rsp_q.slot_out <= tgt_out_ext[SW-1:0];
					rsp_q.hit <= hit_q;
					rsp_q.evicted <= !hit_q;
					rsp_q.status <= rlsc_pkg::ST_OK;
				end
				rlsc_pkg::RES_FULL: begin
					rsp_q.slot_out <= '0;
					rsp_q.hit <= 1'b0;
					rsp_q.evicted <= 1'b0;
					rsp_q.status <= rlsc_pkg::ST_FULL;
				end
				default: begin
					rsp_q.slot_out <= req_q.slot_in;
					rsp_q.hit <= 1'b0;
					rsp_q.evicted <= 1'b0;
					rsp_q.status <= rel_ok ? rlsc_pkg::ST_OK : rlsc_pkg::ST_BAD_RELEASE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			recent_head_q <= NONE;
		end else begin
			if (cmd.fill) begin
				free_head_q <= free_head_q + 1'b1;
				recent_head_q <= free_head_q;
			end else if (cmd.relink) begin
				recent_head_q <= tgt_q;
			end
		end
	end

	always_comb begin
		stat.kind_rel = (req_q.kind == rlsc_pkg::KIND_RELEASE);
		stat.head_none = (recent_head_q == NONE);
		stat.key_match = key_match;
		stat.link_none = (link_rd_q == NONE);
		stat.free_avail = (free_head_q != NONE);
		stat.tgt_valid = (tgt_q != NONE);
		stat.tprev_none = (tprev_q == NONE);
		stat.rel_ok = rel_ok;
	end

	assign result = rsp_q;

`ifndef NO_ASSERTIONS
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q <= NONE)
		else $error("Free slot counter ran past the pool size.");

	a_head_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(free_head_q == '0) == (recent_head_q == NONE))
		else $error("Recency chain head disagrees with the number of used slots.");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |-> (cur_q < NONE))
		else $error("Chain walk visited a slot outside the pool.");
`endif

endmodule

>>> rtl/refcounted_lru_slot_cache_core.sv
// Reference-counted LRU slot cache.
// An item is accepted on a rising edge where start is high and busy is low.
// An acquire item looks up its key along the recency chain; a hit bumps the
// count and moves the slot to the front, a miss takes the next never-used
// slot or reclaims the least recently used slot whose count is zero.
// A release item drops one reference from a used slot_in with a nonzero count.
// Each item yields one result, shown on result for exactly one cycle with
// done high; the receiver cannot stall, so the result must be taken then.
// For an acquire, the chain walk sets how long the item takes: it reads one
// chain entry per cycle from the key, count and link memories.
// Busy stays high until the result is registered, so items are handled one
// at a time; a new item may be accepted in the cycle that done is high.
// After reset all slots are unused, the chain is empty and busy is low; the
// memories need no clearing pass, so an item can be accepted at once.
module refcounted_lru_slot_cache_core #(
	parameter int SLOTS = rlsc_pkg::SLOTS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input rlsc_pkg::req_t request,
	output logic done,
	output rlsc_pkg::rsp_t result
);

	rlsc_pkg::dp_cmd_t cmd;
	rlsc_pkg::dp_stat_t stat;

	rlsc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.done(done),
		.stat(stat),
		.cmd(cmd)
	);

	rlsc_datapath #(
		.SLOTS(SLOTS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.request(request),
		.cmd(cmd),
		.stat(stat),
		.result(result)
	);

endmodule

>>> verif/refcounted_lru_slot_cache_core_tb.sv
`timescale 1ns / 1ps

module refcounted_lru_slot_cache_core_tb;
	import rlsc_pkg::*;

	localparam int SLOTS = SLOTS_DEFAULT;
	localparam int NO_SLOT = SLOTS;
	localparam int KEY_POOL = 24;
	localparam int FULL_COUNT = (1 << COUNT_W) - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t request = '0;
	logic busy;
	logic done;
	rsp_t result;

	logic [KEY_W-1:0] tag_mem[SLOTS];
	logic [COUNT_W-1:0] refs[SLOTS];
	bit in_use[SLOTS];
	int chain_next[SLOTS];
	int mru_head;
	int free_next;
	logic [KEY_W-1:0] key_pool[KEY_POOL];
	rsp_t pending[$];
	int mismatches = 0;

	refcounted_lru_slot_cache_core #(.SLOTS(SLOTS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#100ms;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic void bring_front(int s, int prev);
		if (prev == NO_SLOT)
			return;
		chain_next[prev] = chain_next[s];
		chain_next[s] = mru_head;
		mru_head = s;
	endfunction

	// Applies one item to the cache image and returns the result it should give.
	function automatic rsp_t cache_lookup(req_t r);
		rsp_t o;
		int s;
		int prev;
		int victim;
		int victim_prev;
		int n;
		o = '0;
		if (r.kind == KIND_RELEASE) begin
			s = r.slot_in;
			o.slot_out = r.slot_in;
			if (s >= SLOTS || !in_use[s] || refs[s] == '0) begin
				o.status = ST_BAD_RELEASE;
			end else begin
				refs[s] = refs[s] - 1'b1;
				o.status = ST_OK;
			end
			return o;
		end
		prev = NO_SLOT;
		s = mru_head;
		for (n = 0; n < SLOTS && s < SLOTS && in_use[s]; n++) begin
			if (tag_mem[s] == r.key) begin
				if (refs[s] != FULL_COUNT)
					refs[s] = refs[s] + 1'b1;
				bring_front(s, prev);
				o.slot_out = SLOT_W'(s);
				o.hit = 1'b1;
				o.status = ST_OK;
				return o;
			end
			prev = s;
			s = chain_next[s];
		end
		if (free_next < SLOTS) begin
			s = free_next;
			free_next = chain_next[s];
			in_use[s] = 1'b1;
			refs[s] = COUNT_W'(1);
			tag_mem[s] = r.key;
			chain_next[s] = mru_head;
			mru_head = s;
			o.slot_out = SLOT_W'(s);
			o.status = ST_OK;
			return o;
		end
		victim = NO_SLOT;
		victim_prev = NO_SLOT;
		prev = NO_SLOT;
		s = mru_head;
		for (n = 0; n < SLOTS && s < SLOTS; n++) begin
			if (in_use[s] && refs[s] == '0) begin
				victim = s;
				victim_prev = prev;
			end
			prev = s;
			s = chain_next[s];
		end
		if (victim < SLOTS) begin
			refs[victim] = COUNT_W'(1);
			tag_mem[victim] = r.key;
			bring_front(victim, victim_prev);
			o.slot_out = SLOT_W'(victim);
			o.evicted = 1'b1;
			o.status = ST_OK;
			return o;
		end
		o.status = ST_FULL;
		return o;
	endfunction

	function automatic logic [KEY_W-1:0] random_key();
		return {$urandom, $urandom};
	endfunction

	function automatic req_t make_acquire(logic [KEY_W-1:0] k);
		req_t r;
		r.kind = KIND_ACQUIRE;
		r.key = k;
		r.slot_in = SLOT_W'($urandom_range(SLOTS - 1));
		return r;
	endfunction

	function automatic req_t make_release(logic [SLOT_W-1:0] s);
		req_t r;
		r.kind = KIND_RELEASE;
		r.key = random_key();
		r.slot_in = s;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatches < 40)
			$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic send_item(req_t r, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		request <= r;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		pending.push_back(cache_lookup(r));
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (done === 1'b1) begin
			if (pending.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: %p", result));
			end else begin
				want = pending.pop_front();
				if (result.slot_out !== want.slot_out || result.hit !== want.hit ||
						result.evicted !== want.evicted || result.status !== want.status)
					report_mismatch($sformatf("got %p, want %p", result, want));
			end
		end
	end

	task automatic test_first_fills();
		send_item(make_acquire('0), 0);
		send_item(make_acquire('1), 0);
		send_item(make_acquire('0), 0);
		send_item(make_acquire({32{2'b10}}), 0);
		send_item(make_acquire({32{2'b01}}), 0);
		send_item(make_acquire('1), 0);
		send_item(make_release(4'd15), 0);
		send_item(make_release(4'd0), 0);
		send_item(make_release(4'd0), 0);
		send_item(make_release(4'd0), 0);
	endtask

	task automatic test_evict_and_full();
		repeat (SLOTS - 4)
			send_item(make_acquire(random_key()), 69);
		send_item(make_acquire(random_key()), 69);
		send_item(make_acquire(random_key()), 69);
		send_item(make_release(4'd2), 69);
		send_item(make_release(4'd3), 69);
		send_item(make_acquire(random_key()), 69);
	endtask

	task automatic test_random_traffic(int idle_pct, int count);
		int acq_pct;
		int i;
		acq_pct = 50;
		for (i = 0; i < KEY_POOL; i++)
			key_pool[i] = random_key();
		for (i = 0; i < count; i++) begin
			if (i % 50 == 0)
				acq_pct = $urandom_range(30, 75);
			if ($urandom_range(99) < acq_pct) begin
				if ($urandom_range(99) < 85)
					send_item(make_acquire(key_pool[$urandom_range(KEY_POOL - 1)]), idle_pct);
				else
					send_item(make_acquire(random_key()), idle_pct);
			end else begin
				send_item(make_release(SLOT_W'($urandom_range(SLOTS - 1))), idle_pct);
			end
		end
	endtask

	initial begin
		int i;
		for (i = 0; i < SLOTS; i++) begin
			refs[i] = '0;
			in_use[i] = 1'b0;
			chain_next[i] = i + 1;
		end
		chain_next[SLOTS - 1] = NO_SLOT;
		mru_head = NO_SLOT;
		free_next = 0;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_first_fills();
		test_evict_and_full();
		test_random_traffic(0, 350);
		test_random_traffic(69, 350);
		wait_drained();
		test_random_traffic(22, 350);
		test_random_traffic(0, 350);
		test_random_traffic(69, 350);
		wait_drained();
		repeat (SLOTS + 8)
			@(posedge clk);
		if (mismatches == 0 && pending.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
